@@ rtl/core/bpa_pkg.sv @@
// Shared types, codes and reset-image functions for the buddy page allocator.
// No dependencies; bpa_ctrl and buddy_page_allocator_unit import this package.
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int BPA_FRAME_COUNT     = 4096;
    localparam int BPA_MAX_ORDER       = 10;
    localparam int BPA_FRAME_SIZE_LOG2 = 12;

    localparam int TDATA_W = 40;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_OUT_OF_MEM  = 3'd1,
        STAT_BAD_ORDER   = 3'd2,
        STAT_BAD_ADDR    = 3'd3,
        STAT_DOUBLE_FREE = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_A_SRCH,
        ST_F_RANGE,
        ST_F_ALIGN,
        ST_D_RD,
        ST_D_CHK,
        ST_M_TEST,
        ST_M_CHK,
        ST_U_RD,
        ST_U_WR,
        ST_UP_RD,
        ST_UP_WR,
        ST_UN_RD,
        ST_UN_WR,
        ST_U_END,
        ST_SPLIT,
        ST_PH_WR,
        ST_PH_RD,
        ST_PH_HW,
        ST_PH_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        func;
        logic [3:0]  order;
        logic [31:0] address;
    } bpa_req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] address;
    } bpa_res_t;

    typedef struct packed {
        logic [31:0] nxt;
        logic [31:0] prv;
        logic [3:0]  ord;
        logic        fr;
    } init_ent_t;

    // Frame table entry after the reset cut: full-size blocks first, then
    // at most one smaller block per order in descending order.
    function automatic init_ent_t init_entry(int fc, int mo, int i);
        init_ent_t e;
        int full;
        int rem;
        int blk;
        full  = (fc >> mo) << mo;
        rem   = fc - full;
        blk   = 1 << mo;
        e.nxt = 32'(fc);
        e.prv = 32'(fc);
        e.ord = 4'd0;
        e.fr  = 1'b0;
        if (i < full)
        begin
            if ((i & (blk - 1)) == 0)
            begin
                e.fr  = 1'b1;
                e.ord = 4'(mo);
                e.nxt = (i >= blk) ? 32'(i - blk) : 32'(fc);
                e.prv = ((i + blk) < full) ? 32'(i + blk) : 32'(fc);
            end
        end
        else
        begin
            for (int o = 0; o < mo; o++)
            begin
                if (((rem >> o) & 1) == 1 && (i - full) == (rem & ~((2 << o) - 1)))
                begin
                    e.fr  = 1'b1;
                    e.ord = 4'(o);
                end
            end
        end
        return e;
    endfunction

    function automatic int init_head(int fc, int mo, int o);
        int full;
        int rem;
        full = (fc >> mo) << mo;
        rem  = fc - full;
        if (o == mo)
            return (full > 0) ? (full - (1 << mo)) : fc;
        return (((rem >> o) & 1) == 1) ? (full + (rem & ~((2 << o) - 1))) : fc;
    endfunction

endpackage

@@ rtl/core/bpa_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
// Stand-alone; used for the frame table of the buddy allocator.
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/bpa_ctrl.sv @@
// Allocation sequencer: list heads, address checks and the read-modify-write
// walk over the frame table. Depends on bpa_pkg; drives one bpa_ram.
`timescale 1ns / 1ps

module bpa_ctrl
    import bpa_pkg::*;
#(
    parameter int FRAME_COUNT     = BPA_FRAME_COUNT,
    parameter int MAX_ORDER       = BPA_MAX_ORDER,
    parameter int FRAME_SIZE_LOG2 = BPA_FRAME_SIZE_LOG2,
    localparam int AW  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1,
    localparam int IW  = $clog2(FRAME_COUNT + 1),
    localparam int ENW = 2 * IW + 5
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     frames_base,
    input  logic            req_valid,
    output logic            req_ready,
    input  bpa_req_t        req,
    output logic            res_valid,
    input  logic            res_ready,
    output bpa_res_t        res,
    output logic            ram_we,
    output logic [AW-1:0]   ram_waddr,
    output logic [ENW-1:0]  ram_wdata,
    output logic            ram_re,
    output logic [AW-1:0]   ram_raddr,
    input  logic [ENW-1:0]  ram_rdata
);

    localparam int OW = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
    localparam int WW = $clog2(FRAME_COUNT + (1 << MAX_ORDER) + 1);
    localparam int EW = (((IW + FRAME_SIZE_LOG2) > 32) ? (IW + FRAME_SIZE_LOG2) : 32) + 1;
    localparam logic [IW-1:0] NIL = IW'(FRAME_COUNT);

    state_t         state_reg, state_next;
    logic [AW-1:0]  init_cnt_reg, init_cnt_next;
    logic [IW-1:0]  head_reg [MAX_ORDER+1];
    logic [IW-1:0]  head_next [MAX_ORDER+1];
    logic           func_reg, func_next;
    logic [OW-1:0]  ord_reg, ord_next;
    logic [OW-1:0]  o_reg, o_next;
    logic [31:0]    addr_reg, addr_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [AW-1:0]  tgt_reg, tgt_next;
    logic [AW-1:0]  push_reg, push_next;
    logic [IW-1:0]  p_reg, p_next;
    logic [IW-1:0]  n_reg, n_next;
    logic [IW-1:0]  h_reg, h_next;
    status_t        status_reg, status_next;
    logic [31:0]    raddr_reg, raddr_next;

    logic [IW-1:0]  rd_nxt, rd_prv;
    logic [3:0]     rd_ord;
    logic           rd_free;
    logic [WW-1:0]  pow_o, pow_ord, idx_w, buddy_w, dist_w;
    logic [EW-1:0]  range_end;
    logic [31:0]    off;
    logic           range_bad;
    logic [IW-1:0]  head_o;
    init_ent_t      ie;

    assign rd_nxt  = ram_rdata[2*IW+4:IW+5];
    assign rd_prv  = ram_rdata[IW+4:5];
    assign rd_ord  = ram_rdata[4:1];
    assign rd_free = ram_rdata[0];

    assign pow_o     = WW'(1) << o_reg;
    assign pow_ord   = WW'(1) << ord_reg;
    assign idx_w     = WW'(idx_reg);
    assign buddy_w   = idx_w ^ pow_o;
    assign dist_w    = idx_w - WW'(tgt_reg);
    assign head_o    = head_reg[o_reg];
    assign range_end = EW'(frames_base) + (EW'(FRAME_COUNT) << FRAME_SIZE_LOG2);
    assign off       = addr_reg - frames_base;
    assign range_bad = (addr_reg < frames_base) || (EW'(addr_reg) >= range_end);
    assign ie        = init_entry(FRAME_COUNT, MAX_ORDER, int'(init_cnt_reg));

    assign res.status  = status_reg;
    assign res.address = raddr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            init_cnt_reg <= '0;
            for (int o = 0; o <= MAX_ORDER; o++)
                head_reg[o] <= IW'(init_head(FRAME_COUNT, MAX_ORDER, o));
        end
        else
        begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            head_reg     <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        ord_reg    <= ord_next;
        o_reg      <= o_next;
        addr_reg   <= addr_next;
        idx_reg    <= idx_next;
        tgt_reg    <= tgt_next;
        push_reg   <= push_next;
        p_reg      <= p_next;
        n_reg      <= n_next;
        h_reg      <= h_next;
        status_reg <= status_next;
        raddr_reg  <= raddr_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        head_next     = head_reg;
        func_next     = func_reg;
        ord_next      = ord_reg;
        o_next        = o_reg;
        addr_next     = addr_reg;
        idx_next      = idx_reg;
        tgt_next      = tgt_reg;
        push_next     = push_reg;
        p_next        = p_reg;
        n_next        = n_reg;
        h_next        = h_reg;
        status_next   = status_reg;
        raddr_next    = raddr_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        req_ready     = 1'b0;
        res_valid     = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = init_cnt_reg;
                ram_wdata = {IW'(ie.nxt), IW'(ie.prv), ie.ord, ie.fr};
                init_cnt_next = init_cnt_reg + AW'(1);
                if (init_cnt_reg == AW'(FRAME_COUNT - 1))
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    func_next  = req.func;
                    addr_next  = req.address;
                    ord_next   = OW'(req.order);
                    o_next     = OW'(req.order);
                    raddr_next = '0;
                    if (req.order > 4'(MAX_ORDER))
                    begin
                        status_next = STAT_BAD_ORDER;
                        state_next  = ST_DONE;
                    end
                    else if (req.func == FUNC_ALLOC)
                        state_next = ST_A_SRCH;
                    else
                        state_next = ST_F_RANGE;
                end
            end

            // climb the orders until a list has a block or the top order is found empty
            ST_A_SRCH:
            begin
                if (head_o != NIL)
                begin
                    idx_next   = AW'(head_o);
                    tgt_next   = AW'(head_o);
                    state_next = ST_U_RD;
                end
                else if (o_reg == OW'(MAX_ORDER))
                begin
                    status_next = STAT_OUT_OF_MEM;
                    state_next  = ST_DONE;
                end
                else
                    o_next = o_reg + OW'(1);
            end

            ST_F_RANGE:
            begin
                idx_next = AW'(off >> FRAME_SIZE_LOG2);
                if (range_bad || off[FRAME_SIZE_LOG2-1:0] != '0)
                begin
                    status_next = STAT_BAD_ADDR;
                    state_next  = ST_DONE;
                end
                else
                    state_next = ST_F_ALIGN;
            end

            ST_F_ALIGN:
            begin
                if ((idx_w & (pow_ord - WW'(1))) != '0 ||
                    (idx_w + pow_ord) > WW'(FRAME_COUNT))
                begin
                    status_next = STAT_BAD_ADDR;
                    state_next  = ST_DONE;
                end
                else
                begin
                    o_next     = '0;
                    state_next = ST_D_RD;
                end
            end

            // probe the aligned start at each order for a covering free block
            ST_D_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg & ~AW'(pow_o - WW'(1));
                tgt_next   = idx_reg & ~AW'(pow_o - WW'(1));
                state_next = ST_D_CHK;
            end

            ST_D_CHK:
            begin
                if (rd_free && dist_w < (WW'(1) << rd_ord))
                begin
                    status_next = STAT_DOUBLE_FREE;
                    state_next  = ST_DONE;
                end
                else if (o_reg == OW'(MAX_ORDER))
                begin
                    o_next     = ord_reg;
                    state_next = ST_M_TEST;
                end
                else
                begin
                    o_next     = o_reg + OW'(1);
                    state_next = ST_D_RD;
                end
            end

            ST_M_TEST:
            begin
                if (o_reg == OW'(MAX_ORDER) || buddy_w >= WW'(FRAME_COUNT))
                begin
                    push_next  = idx_reg;
                    state_next = ST_PH_WR;
                end
                else
                begin
                    tgt_next   = AW'(buddy_w);
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(buddy_w);
                    state_next = ST_M_CHK;
                end
            end

            ST_M_CHK:
            begin
                if (rd_free && rd_ord == 4'(o_reg))
                    state_next = ST_U_RD;
                else
                begin
                    push_next  = idx_reg;
                    state_next = ST_PH_WR;
                end
            end

            // unlink tgt_reg from the list of order o_reg
            ST_U_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = tgt_reg;
                state_next = ST_U_WR;
            end

            ST_U_WR:
            begin
                p_next    = rd_prv;
                n_next    = rd_nxt;
                ram_we    = 1'b1;
                ram_waddr = tgt_reg;
                ram_wdata = {NIL, NIL, 4'(o_reg), 1'b0};
                if (rd_prv != NIL)
                    state_next = ST_UP_RD;
                else
                begin
                    head_next[o_reg] = rd_nxt;
                    state_next = (rd_nxt != NIL) ? ST_UN_RD : ST_U_END;
                end
            end

            ST_UP_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(p_reg);
                state_next = ST_UP_WR;
            end

            ST_UP_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(p_reg);
                ram_wdata  = {n_reg, rd_prv, rd_ord, rd_free};
                state_next = (n_reg != NIL) ? ST_UN_RD : ST_U_END;
            end

            ST_UN_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(n_reg);
                state_next = ST_UN_WR;
            end

            ST_UN_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(n_reg);
                ram_wdata  = {rd_nxt, p_reg, rd_ord, rd_free};
                state_next = ST_U_END;
            end

            ST_U_END:
            begin
                if (func_reg == FUNC_ALLOC)
                    state_next = ST_SPLIT;
                else
                begin
                    if (tgt_reg < idx_reg)
                        idx_next = tgt_reg;
                    o_next     = o_reg + OW'(1);
                    state_next = ST_M_TEST;
                end
            end

            // halve the block and hand the upper half back, or return the address at the requested order
            ST_SPLIT:
            begin
                if (o_reg > ord_reg)
                begin
                    o_next     = o_reg - OW'(1);
                    push_next  = AW'(idx_w + (WW'(1) << (o_reg - OW'(1))));
                    state_next = ST_PH_WR;
                end
                else
                begin
                    status_next = STAT_OK;
                    raddr_next  = frames_base + (32'(idx_reg) << FRAME_SIZE_LOG2);
                    state_next  = ST_DONE;
                end
            end

            // push push_reg at the head of the list of order o_reg
            ST_PH_WR:
            begin
                h_next    = head_o;
                ram_we    = 1'b1;
                ram_waddr = push_reg;
                ram_wdata = {head_o, NIL, 4'(o_reg), 1'b1};
                head_next[o_reg] = IW'(push_reg);
                state_next = (head_o != NIL) ? ST_PH_RD : ST_PH_END;
            end

            ST_PH_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(h_reg);
                state_next = ST_PH_HW;
            end

            ST_PH_HW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(h_reg);
                ram_wdata  = {rd_nxt, IW'(push_reg), rd_ord, rd_free};
                state_next = ST_PH_END;
            end

            ST_PH_END:
            begin
                if (func_reg == FUNC_ALLOC)
                    state_next = ST_SPLIT;
                else
                begin
                    status_next = STAT_OK;
                    state_next  = ST_DONE;
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/buddy_page_allocator_unit.sv @@
// Top level of the buddy page allocator: stream ports, base register,
// output register, frame table RAM and sequencer. Depends on bpa_pkg,
// bpa_ram and bpa_ctrl.
`timescale 1ns / 1ps

// Binary buddy allocator over FRAME_COUNT frames of 2**FRAME_SIZE_LOG2 bytes
// starting at byte address frames_base. Each input word is an alloc or a
// free of a block of 2**block_order frames; each yields exactly one output
// word with a status and, for a good alloc, the block's byte address. After
// reset the block writes the initial frame table, one entry per frame
// (s_tready low, base writes still taken). A request then runs in steps: a
// bad order or address is rejected before any table access; a free probes
// every order for a covering free block, then merges with free buddies order
// by order and pushes the result; an alloc searches the orders upward, unlinks
// the block found and splits it down to the requested order. The pace is set
// by the single frame-table RAM, which every list step reads and writes back
// one entry at a time. A finished result sits in the output register while
// the next request is taken.
module buddy_page_allocator_unit
    import bpa_pkg::*;
#(
    parameter int FRAME_COUNT     = BPA_FRAME_COUNT,
    parameter int MAX_ORDER       = BPA_MAX_ORDER,
    parameter int FRAME_SIZE_LOG2 = BPA_FRAME_SIZE_LOG2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // block_order [3:0], block_address [35:4]
    input  logic [0:0]         s_tuser,   // func [0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata    // status [2:0], result_address [34:3]
);

    localparam int AW  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int IW  = $clog2(FRAME_COUNT + 1);
    localparam int ENW = 2 * IW + 5;

    logic [31:0]        base_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    bpa_req_t       req;
    bpa_res_t       res;
    logic           res_valid, res_ready;
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [ENW-1:0] ram_wdata, ram_rdata;

    assign req.func    = s_tuser[0];
    assign req.order   = s_tdata[3:0];
    assign req.address = s_tdata[35:4];

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                base_reg <= cfg_wr_data;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    // load a new word when the register is empty or being drained
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_ready)
        begin
            m_tvalid_next = res_valid;
            if (res_valid)
                m_tdata_next = TDATA_W'({res.address, res.status});
        end
    end

    bpa_ram #(
        .WIDTH (ENW),
        .DEPTH (FRAME_COUNT)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    bpa_ctrl #(
        .FRAME_COUNT     (FRAME_COUNT),
        .MAX_ORDER       (MAX_ORDER),
        .FRAME_SIZE_LOG2 (FRAME_SIZE_LOG2)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frames_base (base_reg),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

endmodule
